// File: design/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared constants for the sliding-window maximum unit
// Sample and register widths, reset value of the window length and the
// default depth of the candidate chain.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned SampleW          = 32;
  localparam int unsigned CfgW             = 7;
  localparam int unsigned DefaultMaxWindow = 64;
  localparam logic [CfgW-1:0] WindowLenReset = 7'd1;

endpackage

// File: design/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one candidate slot of the monotonic chain
// Holds one candidate value with its age. On a sample it takes its own or its
// back neighbour's candidate, keeps it if it beats the sample, or takes the
// sample itself when it is the first slot after the kept run.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int unsigned AgeW = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  logic                                 clear_i,
  input  logic                                 shift_i,
  input  logic                                 prune_i,
  input  logic signed [swm_pkg::SampleW-1:0]   sample_i,
  input  logic                                 nxt_valid_i,
  input  logic signed [swm_pkg::SampleW-1:0]   nxt_value_i,
  input  logic        [AgeW-1:0]               nxt_age_i,
  input  logic                                 prv_keep_i,
  output logic                                 keep_o,
  output logic                                 valid_o,
  output logic signed [swm_pkg::SampleW-1:0]   value_o,
  output logic        [AgeW-1:0]               age_o,
  output logic signed [swm_pkg::SampleW-1:0]   value_next_o
);

  logic                                valid_q, valid_d;
  logic signed [swm_pkg::SampleW-1:0]  value_q, value_d;
  logic        [AgeW-1:0]              age_q, age_d;
  logic                                src_valid;
  logic signed [swm_pkg::SampleW-1:0]  src_value;
  logic        [AgeW-1:0]              src_age;
  logic                                is_new;

  always_comb begin
    src_valid = shift_i ? nxt_valid_i : valid_q;
    src_value = shift_i ? nxt_value_i : value_q;
    src_age   = shift_i ? nxt_age_i   : age_q;
    keep_o    = step_i && !clear_i && src_valid && (src_value > sample_i);
    is_new    = !keep_o && prv_keep_i;
    valid_d   = valid_q;
    value_d   = value_q;
    age_d     = age_q;
    if (step_i) begin
      valid_d = keep_o || is_new;
      value_d = is_new ? sample_i : src_value;
      age_d   = is_new ? '0 : AgeW'(src_age + AgeW'(1));
    end else if (prune_i) begin
      // drop the front: take the neighbour's candidate unchanged
      valid_d = nxt_valid_i;
      value_d = nxt_value_i;
      age_d   = nxt_age_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

  assign valid_o      = valid_q;
  assign value_o      = value_q;
  assign age_o        = age_q;
  assign value_next_o = value_d;

endmodule

// File: design/swm_obuf.sv
// ----------------------------------------------------------------------------
// swm_obuf: two-entry result buffer
// Parts the sample side from the result side so a new sample can be taken
// while a finished result still waits downstream.
// ----------------------------------------------------------------------------
module swm_obuf (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic signed [swm_pkg::SampleW-1:0]  data_i,
  output logic                                full_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [swm_pkg::SampleW-1:0]  data_o
);

  logic signed [swm_pkg::SampleW-1:0] mem_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_q, wr_d, rd_q, rd_d;
  logic       pop;

  assign pop = (count_q != 2'd0) && !out_stall_i;

  always_comb begin
    wr_d    = push_i ? ~wr_q : wr_q;
    rd_d    = pop ? ~rd_q : rd_q;
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign data_o      = mem_q[rd_q];

endmodule

// File: design/sliding_window_max_unit.sv
// ----------------------------------------------------------------------------
// Result: each result is registered in the two-entry output buffer when its sample is taken.
// Throughput: one sample per cycle while the output buffer is not full; after the window
// length is shortened the chain drops stale front candidates one per cycle first, and
// no sample is taken while it does.
// Reset: all candidates invalid, fill count zero, window length 1, no result held.
// ----------------------------------------------------------------------------
// sliding_window_max_unit: running maximum over the last window_len samples
// A chain of cells keeps a monotonic list of candidates, oldest and largest at
// cell 0. Each sample ages the list, drops the front if it has left the window,
// drops the tail that does not beat the sample and appends the sample.
// ----------------------------------------------------------------------------
module sliding_window_max_unit #(
  parameter int unsigned MAX_WINDOW = swm_pkg::DefaultMaxWindow
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [swm_pkg::SampleW-1:0]  sample_i,
  input  logic                                new_sequence_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [swm_pkg::SampleW-1:0]  window_max_o,
  // window length register
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [swm_pkg::CfgW-1:0]     cfg_window_len_i
);

  localparam int unsigned AgeW = $clog2(MAX_WINDOW);
  localparam int unsigned LenW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CmpW = (LenW > swm_pkg::CfgW) ? LenW : swm_pkg::CfgW;

  logic [swm_pkg::CfgW-1:0] window_len_q;
  logic [LenW-1:0]          fill_q, fill_d;
  logic [LenW-1:0]          eff_len;
  logic [CmpW-1:0]          len_ext;
  logic [LenW:0]            fill_inc;
  logic                     step, clear, shift, prune, prune_need, front_aged;
  logic                     obuf_full, has_result;

  logic                                c_valid [MAX_WINDOW];
  logic signed [swm_pkg::SampleW-1:0]  c_value [MAX_WINDOW];
  logic        [AgeW-1:0]              c_age   [MAX_WINDOW];
  logic                                c_keep  [MAX_WINDOW];
  logic signed [swm_pkg::SampleW-1:0]  c_next  [MAX_WINDOW];

  // Configuration: always ready; the user must write it only while the block is idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= swm_pkg::WindowLenReset;
    end else if (cfg_valid_i) begin
      window_len_q <= cfg_window_len_i;
    end
  end

  // Effective length: zero acts as one, anything past the chain depth is clamped.
  always_comb begin
    len_ext = CmpW'(window_len_q);
    if (len_ext == '0) begin
      eff_len = LenW'(1);
    end else if (len_ext > CmpW'(MAX_WINDOW)) begin
      eff_len = LenW'(MAX_WINDOW);
    end else begin
      eff_len = LenW'(len_ext);
    end
  end

  // Stale candidates: only the front can leave the window on an ordinary
  // sample. After a shortened window several may be stale; while the second
  // one is, drop the front one per cycle and hold the sample channel.
  assign prune_need = c_valid[1] && ((LenW'(c_age[1]) + LenW'(1)) >= eff_len);
  assign front_aged = c_valid[0] && ((LenW'(c_age[0]) + LenW'(1)) >= eff_len);

  assign in_stall_o = prune_need || obuf_full;
  assign step       = in_valid_i && !in_stall_o;
  assign clear      = new_sequence_i;
  assign prune      = prune_need && !step;
  assign shift      = (step && !clear && front_aged) || prune;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    logic                               nxt_valid;
    logic signed [swm_pkg::SampleW-1:0] nxt_value;
    logic        [AgeW-1:0]             nxt_age;
    logic                               prv_keep;

    if (g == MAX_WINDOW - 1) begin : g_tail
      assign nxt_valid = 1'b0;
      assign nxt_value = '0;
      assign nxt_age   = '0;
    end else begin : g_mid
      assign nxt_valid = c_valid[g+1];
      assign nxt_value = c_value[g+1];
      assign nxt_age   = c_age[g+1];
    end

    if (g == 0) begin : g_head
      assign prv_keep = 1'b1;
    end else begin : g_body
      assign prv_keep = c_keep[g-1];
    end

    swm_cell #(
      .AgeW (AgeW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .step_i       (step),
      .clear_i      (clear),
      .shift_i      (shift),
      .prune_i      (prune),
      .sample_i     (sample_i),
      .nxt_valid_i  (nxt_valid),
      .nxt_value_i  (nxt_value),
      .nxt_age_i    (nxt_age),
      .prv_keep_i   (prv_keep),
      .keep_o       (c_keep[g]),
      .valid_o      (c_valid[g]),
      .value_o      (c_value[g]),
      .age_o        (c_age[g]),
      .value_next_o (c_next[g])
    );
  end

  // Fill count: restart on a new sequence, saturate at the effective length.
  always_comb begin
    fill_inc   = (clear ? '0 : {1'b0, fill_q}) + (LenW+1)'(1);
    fill_d     = (fill_inc < {1'b0, eff_len}) ? LenW'(fill_inc) : eff_len;
    has_result = (fill_d == eff_len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (step) begin
      fill_q <= fill_d;
    end
  end

  // Result: the new front candidate once the window has filled.
  swm_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step && has_result),
    .data_i      (c_next[0]),
    .full_o      (obuf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (window_max_o)
  );

endmodule

// File: design/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker: port-level checks for the sliding-window maximum unit
// Watches the handshakes and reset behaviour seen on the top-level ports.
// ----------------------------------------------------------------------------
module swm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [swm_pkg::SampleW-1:0]  window_max_o
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_max_o))
    else $error("stalled result changed or vanished");

  // A result only follows a sample transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result appeared without a sample");

  // Reset drops any held result.
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind sliding_window_max_unit swm_checker u_swm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .window_max_o (window_max_o)
);

// File: tb/sliding_window_max_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_max_unit_tb: self-checking bench for the window maximum unit
// Directed rows cover the sample extremes, all-negative windows, equal
// values, zero and oversized lengths and length changes in mid-sequence.
// Random phases follow, each with its own window length. An in-bench model
// of the candidate list predicts each result that the table does not type. Random gaps on the sender and
// random stalls on the receiver move the handshakes about.
// ----------------------------------------------------------------------------
module sliding_window_max_unit_tb;

  localparam int unsigned MaxWin   = swm_pkg::DefaultMaxWindow;
  localparam int unsigned SmpW     = swm_pkg::SampleW;
  localparam int unsigned LenW     = swm_pkg::CfgW;
  localparam int          RandItems = 1850;

  typedef logic signed [SmpW-1:0] smp_t;

  // One directed row: optional length write (once idle), then one sample.
  typedef struct packed {
    bit            do_cfg;
    logic [6:0]    cfg_len;
    smp_t          smp;
    logic          nseq;
    bit            typed;
    smp_t          tv;
  } vec_t;

  localparam smp_t SmpMin = 32'sh8000_0000;
  localparam smp_t SmpMax = 32'sh7FFF_FFFF;

  localparam vec_t DirVecs [24] = '{
    // length 1 after reset: every sample is its own maximum
    '{1'b0, 7'd0,   32'sd5,  1'b0, 1'b1, 32'sd5},
    '{1'b0, 7'd0,   SmpMin,  1'b0, 1'b1, SmpMin},
    '{1'b0, 7'd0,   SmpMax,  1'b0, 1'b1, SmpMax},
    '{1'b0, 7'd0,   -32'sd1, 1'b0, 1'b1, -32'sd1},
    // zero length behaves as one
    '{1'b1, 7'd0,   SmpMin,  1'b1, 1'b1, SmpMin},
    '{1'b0, 7'd0,   32'sd7,  1'b0, 1'b1, 32'sd7},
    // length 3, all-negative window, then equal values
    '{1'b1, 7'd3,   -32'sd5, 1'b1, 1'b0, 32'sd0},
    '{1'b0, 7'd0,   -32'sd7, 1'b0, 1'b0, 32'sd0},
    '{1'b0, 7'd0,   -32'sd6, 1'b0, 1'b1, -32'sd5},
    '{1'b0, 7'd0,   -32'sd8, 1'b0, 1'b1, -32'sd6},
    '{1'b0, 7'd0,   32'sd4,  1'b0, 1'b1, 32'sd4},
    '{1'b0, 7'd0,   32'sd4,  1'b0, 1'b1, 32'sd4},
    '{1'b0, 7'd0,   32'sd4,  1'b0, 1'b1, 32'sd4},
    '{1'b0, 7'd0,   -32'sd3, 1'b0, 1'b1, 32'sd4},
    // grow in mid-sequence: results pause until the window refills
    '{1'b1, 7'd5,   32'sd9,  1'b0, 1'b0, 32'sd0},
    '{1'b0, 7'd0,   32'sd1,  1'b0, 1'b0, 32'sd0},
    // shrink in mid-sequence: stale candidates go
    '{1'b1, 7'd2,   32'sd0,  1'b0, 1'b0, 32'sd0},
    '{1'b0, 7'd0,   32'sd2,  1'b0, 1'b0, 32'sd0},
    // largest window, then an oversized length
    '{1'b1, 7'd64,  SmpMax,  1'b1, 1'b0, 32'sd0},
    '{1'b0, 7'd0,   32'sd0,  1'b0, 1'b0, 32'sd0},
    '{1'b1, 7'd127, -32'sd1, 1'b0, 1'b0, 32'sd0},
    '{1'b0, 7'd0,   SmpMax,  1'b1, 1'b0, 32'sd0},
    '{1'b1, 7'd1,   SmpMin,  1'b0, 1'b1, SmpMin},
    '{1'b0, 7'd0,   SmpMax,  1'b1, 1'b1, SmpMax}
  };

  logic              clk_i            = 1'b0;
  logic              rst_ni;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  smp_t              sample_i         = '0;
  logic              new_sequence_i   = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  smp_t              window_max_o;
  logic              cfg_valid_i      = 1'b0;
  logic              cfg_ready_o;
  logic [LenW-1:0]   cfg_window_len_i = '0;

  // Bench-side tag travelling with the sample: a result typed into the table.
  bit                chk_typed        = 1'b0;
  smp_t              chk_val          = '0;

  // Window model state
  smp_t              cand_val [MaxWin];
  int unsigned       cand_age [MaxWin];
  int unsigned       cand_n   = 0;
  int unsigned       fill_cnt = 0;
  logic [LenW-1:0]   len_reg  = swm_pkg::WindowLenReset;

  // Expected results in order: a ring with write and read counters.
  smp_t              exp_mem [256];
  logic [7:0]        exp_wr    = '0;
  logic [7:0]        exp_rd    = '0;
  int                err_cnt   = 0;
  int                calm_left = 0;
  int                slope_left = 0;
  smp_t              last_smp  = '0;

  sliding_window_max_unit #(
    .MAX_WINDOW (MaxWin)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .new_sequence_i   (new_sequence_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_max_o     (window_max_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_window_len_i (cfg_window_len_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the candidate list by one sample; return 1 when a maximum is due.
  function automatic bit slide_window(input smp_t s, input logic nseq, output smp_t mx);
    int unsigned len;
    int unsigned keep;
    len = (len_reg == 0) ? 1 : ((len_reg > MaxWin) ? MaxWin : len_reg);
    mx  = '0;
    if (nseq) begin
      cand_n   = 0;
      fill_cnt = 0;
    end
    // age the list and drop whatever has left the window
    keep = 0;
    for (int unsigned i = 0; i < cand_n; i++) begin
      if (cand_age[i] + 1 < len) begin
        cand_val[keep] = cand_val[i];
        cand_age[keep] = cand_age[i] + 1;
        keep++;
      end
    end
    cand_n = keep;
    // drop the tail that the new sample matches or beats
    while (cand_n > 0 && cand_val[cand_n-1] <= s) cand_n--;
    if (cand_n < MaxWin) begin
      cand_val[cand_n] = s;
      cand_age[cand_n] = 0;
      cand_n++;
    end
    fill_cnt = (fill_cnt + 1 < len) ? fill_cnt + 1 : len;
    if (fill_cnt >= len) begin
      mx = cand_val[0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void note_error(input string what);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t ns: %s", $time, what);
  endfunction

  // Watch every handshake with pre-edge values: results first, since a result
  // always belongs to an older sample than the one taken at the same edge.
  always @(posedge clk_i) begin
    smp_t mx;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (exp_wr == exp_rd) begin
          note_error($sformatf("unexpected result %0d", window_max_o));
        end else begin
          if (window_max_o !== exp_mem[exp_rd])
            note_error($sformatf("window_max expected %0d, got %0d", exp_mem[exp_rd],
                                 window_max_o));
          exp_rd = exp_rd + 8'd1;
        end
      end
      if (cfg_valid_i && cfg_ready_o) len_reg = cfg_window_len_i;
      if (in_valid_i && !in_stall_o) begin
        if (slide_window(sample_i, new_sequence_i, mx) || chk_typed) begin
          exp_mem[exp_wr] = chk_typed ? chk_val : mx;
          exp_wr = exp_wr + 8'd1;
        end
      end
    end
  end

  // Receiver: bursts of stall, mostly short, now and then long or absent.
  initial begin
    int run_len;
    int hold_len;
    int r;
    forever begin
      r = $urandom_range(0, 99);
      run_len = (r < 4) ? $urandom_range(150, 400) : $urandom_range(1, 6);
      out_stall_i <= 1'b0;
      repeat (run_len) @(posedge clk_i);
      r = $urandom_range(0, 99);
      hold_len = (r < 40) ? 0 : ((r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40));
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_left = $urandom_range(50, 200);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mix of narrow values (ties), full-range words, extremes and slow slopes;
  // falling slopes fill the candidate list deep.
  function automatic smp_t next_sample();
    int r;
    if (slope_left > 0) begin
      slope_left--;
      last_smp = last_smp - int'($urandom_range(0, 3));
      return last_smp;
    end
    r = $urandom_range(0, 99);
    if (r < 8) slope_left = $urandom_range(10, 80);
    if (r < 35) begin
      last_smp = int'($urandom_range(0, 16)) - 8;
    end else if (r < 65) begin
      last_smp = $urandom();
    end else if (r < 78) begin
      case ($urandom_range(0, 3))
        0:       last_smp = SmpMin;
        1:       last_smp = SmpMax;
        2:       last_smp = '0;
        default: last_smp = -32'sd1;
      endcase
    end else begin
      last_smp = last_smp + int'($urandom_range(0, 2));
    end
    return last_smp;
  endfunction

  function automatic logic [LenW-1:0] pick_len();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      4:       return LenW'($urandom_range(65, 126));
      5, 6:    return LenW'($urandom_range(13, 63));
      default: return LenW'($urandom_range(2, 12));
    endcase
  endfunction

  // Called at a rising edge; returns at the edge that takes the transaction.
  task automatic send_sample(input smp_t s, input logic nseq, input bit typed, input smp_t tv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_i       <= s;
    new_sequence_i <= nseq;
    chk_typed      <= typed;
    chk_val        <= tv;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold the sender until every result is in, then let the last sample settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (exp_wr != exp_rd);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window_len(input logic [LenW-1:0] len);
    cfg_valid_i      <= 1'b1;
    cfg_window_len_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i      <= 1'b0;
  endtask

  initial begin
    int rand_sent;
    int phase_items;
    int guard;
    bit fresh;
    rand_sent = 0;
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirVecs[k]) begin
      if (DirVecs[k].do_cfg) begin
        wait_drained();
        write_window_len(DirVecs[k].cfg_len);
      end
      send_sample(DirVecs[k].smp, DirVecs[k].nseq, DirVecs[k].typed, DirVecs[k].tv);
    end

    // Random phases: a fresh length per phase, sometimes carried into the
    // running sequence so the change lands in mid-sequence.
    while (rand_sent < RandItems) begin
      wait_drained();
      write_window_len(pick_len());
      phase_items = $urandom_range(40, 140);
      fresh = 1'($urandom_range(0, 1));
      for (int j = 0; j < phase_items; j++) begin
        send_sample(next_sample(), (j == 0 && fresh) || ($urandom_range(0, 39) == 0),
                    1'b0, '0);
        rand_sent++;
      end
    end

    in_valid_i <= 1'b0;
    guard = 0;
    while (exp_wr != exp_rd && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (exp_wr != exp_rd)
      note_error($sformatf("%0d results never arrived", exp_wr - exp_rd));

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
design/swm_pkg.sv
design/swm_cell.sv
design/swm_obuf.sv
design/sliding_window_max_unit.sv
design/swm_checker.sv
tb/sliding_window_max_unit_tb.sv
